// ----- hw/rtl/wbsb_pkg.sv -----
// ----------------------------------------------------------------------------
// wbsb_pkg
// Shared types and codes for the wake buffered serial bridge.
// ----------------------------------------------------------------------------
package wbsb_pkg;

  // Hold buffer depth default and the widest count the command carries
  localparam int HOLD_DEPTH_DEF = 64;
  localparam int HOLD_CNT_W     = 12;   // covers depths up to 4096

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register reset values
  localparam logic [13:0] START_DELAY_RST  = 14'd50;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;

  // Register index codes (paddr[2])
  localparam logic REG_START_DELAY  = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  // Input mode codes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  // Result kind codes
  localparam logic [1:0] KIND_TO_DOWN = 2'd0;
  localparam logic [1:0] KIND_TO_UP   = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // One command from front to back: a single result or a flush of the buffer
  typedef struct packed {
    logic                  flush;
    logic [1:0]            kind;
    logic [7:0]            byte_out;
    logic                  wake;
    logic [HOLD_CNT_W-1:0] count;
  } cmd_t;

  // Hold buffer write port, driven by the front
  typedef struct packed {
    logic                  en;
    logic [HOLD_CNT_W-1:0] addr;
    logic [7:0]            data;
  } hold_wr_t;

  // Back status seen by the front
  typedef struct packed {
    logic flush_done;
  } bk_status_t;

endpackage

// ----- hw/rtl/wbsb_in_if.sv -----
// ----------------------------------------------------------------------------
// wbsb_in_if
// Input channel: valid/ready with mode and data.
// ----------------------------------------------------------------------------
interface wbsb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data;

  modport source (output valid, output mode, output data, input ready);
  modport sink   (input valid, input mode, input data, output ready);
endinterface

// ----- hw/rtl/wbsb_out_if.sv -----
// ----------------------------------------------------------------------------
// wbsb_out_if
// Result channel: valid/ready with kind, byte, wake level and last mark.
// ----------------------------------------------------------------------------
interface wbsb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_out;
  logic       wake_level;
  logic       last;

  modport source (output valid, output kind, output byte_out, output wake_level,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_out, input wake_level,
                  input last, output ready);
endinterface

// ----- hw/rtl/wbsb_front.sv -----
// ----------------------------------------------------------------------------
// wbsb_front
// Accepts requests, runs phase and timer, writes the hold buffer and queues
// one command per request that yields results.
// ----------------------------------------------------------------------------
module wbsb_front import wbsb_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wbsb_in_if.sink     item,
  input  logic [13:0] start_delay,
  input  logic [15:0] idle_timeout,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd,
  output hold_wr_t    hold_wr,
  input  bk_status_t  bk_status
);

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam logic [AW-1:0] WRAP_AT = AW'(HOLD_DEPTH - 1);

  localparam logic [1:0] PH_STOPPED  = 2'd0;
  localparam logic [1:0] PH_STARTING = 2'd1;
  localparam logic [1:0] PH_STARTED  = 2'd2;

  logic [1:0]    phase, phase_next;
  logic [15:0]   ticks_left, ticks_left_next;
  logic          timer_running, timer_running_next;
  logic [AW-1:0] held_count, held_count_next;
  logic          flush_pending;

  logic          accept;
  logic          push, wr;
  logic [AW-1:0] wr_addr;
  logic [15:0]   ticks_dec;

  assign item.ready = !q_full && !flush_pending;
  assign accept     = item.valid && item.ready;

  always_comb begin
    phase_next         = phase;
    ticks_left_next    = ticks_left;
    timer_running_next = timer_running;
    held_count_next    = held_count;
    push               = 1'b0;
    wr                 = 1'b0;
    wr_addr            = held_count;
    q_cmd              = '0;
    ticks_dec          = ticks_left - {15'd0, (ticks_left != 16'd0)};
    unique case (item.mode)
      MODE_TICK: begin
        if (timer_running) begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == 16'd0) begin
            unique case (phase)
              PH_STARTING: begin
                phase_next      = PH_STARTED;
                held_count_next = '0;
                ticks_left_next = idle_timeout;
                if (held_count != '0) begin
                  push        = 1'b1;
                  q_cmd.flush = 1'b1;
                  q_cmd.kind  = KIND_TO_DOWN;
                  q_cmd.wake  = 1'b1;
                  q_cmd.count = HOLD_CNT_W'(held_count);
                end
              end
              PH_STARTED: begin
                phase_next         = PH_STOPPED;
                timer_running_next = 1'b0;
                push               = 1'b1;
                q_cmd.kind         = KIND_STATUS;
                q_cmd.wake         = 1'b0;
              end
              default: timer_running_next = 1'b0;
            endcase
          end
        end
      end
      MODE_UP: begin
        if (phase == PH_STARTED) begin
          ticks_left_next    = idle_timeout;
          timer_running_next = 1'b1;
          push               = 1'b1;
          q_cmd.kind         = KIND_TO_DOWN;
          q_cmd.byte_out     = item.data;
          q_cmd.wake         = 1'b1;
        end else begin
          wr_addr         = (held_count >= WRAP_AT) ? '0 : held_count;
          wr              = 1'b1;
          held_count_next = wr_addr + 1'b1;
          if (phase != PH_STARTING) begin
            phase_next         = PH_STARTING;
            ticks_left_next    = {2'b00, start_delay};
            timer_running_next = 1'b1;
            push               = 1'b1;
            q_cmd.kind         = KIND_STATUS;
            q_cmd.wake         = 1'b1;
          end
        end
      end
      MODE_DOWN: begin
        push           = 1'b1;
        q_cmd.kind     = KIND_TO_UP;
        q_cmd.byte_out = item.data;
        q_cmd.wake     = (phase == PH_STARTING) || (phase == PH_STARTED);
      end
      default: ;
    endcase
  end

  assign q_push       = accept && push;
  assign hold_wr.en   = accept && wr;
  assign hold_wr.addr = HOLD_CNT_W'(wr_addr);
  assign hold_wr.data = item.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_STOPPED;
      ticks_left    <= '0;
      timer_running <= 1'b0;
      held_count    <= '0;
      flush_pending <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        ticks_left    <= ticks_left_next;
        timer_running <= timer_running_next;
        held_count    <= held_count_next;
      end
      if (q_push && q_cmd.flush) begin
        flush_pending <= 1'b1;
      end else if (bk_status.flush_done) begin
        flush_pending <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/wbsb_queue.sv -----
// ----------------------------------------------------------------------------
// wbsb_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module wbsb_queue import wbsb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic avail
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full    = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign avail   = (fill != '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/wbsb_back.sv -----
// ----------------------------------------------------------------------------
// wbsb_back
// Executes queued commands: single results, or a flush of the hold buffer one
// byte per cycle unless stalled. Owns the hold buffer and the output register.
// ----------------------------------------------------------------------------
module wbsb_back import wbsb_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  hold_wr_t   hold_wr,
  output bk_status_t bk_status,
  wbsb_out_if.source result
);

  localparam int AW = $clog2(HOLD_DEPTH);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic [7:0]    hold_mem [HOLD_DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;

  logic          state;
  logic [AW-1:0] idx, cnt;
  logic [AW-1:0] idx_inc;
  logic          out_valid;
  logic          out_free;
  logic          flush_last;

  assign out_free   = !out_valid || result.ready;
  assign idx_inc    = idx + 1'b1;
  assign flush_last = (idx_inc == cnt);
  assign q_pop      = (state == ST_IDLE) && q_avail && out_free;

  // read address runs one ahead of the byte being loaded
  always_comb begin
    rd_addr = '0;
    if (state == ST_FLUSH) begin
      rd_addr = out_free ? idx_inc : idx;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_wr.en) begin
      hold_mem[hold_wr.addr[AW-1:0]] <= hold_wr.data;
    end
    rd_data <= hold_mem[rd_addr];
  end

  assign bk_status.flush_done = (state == ST_FLUSH) && out_free && flush_last;
  assign result.valid         = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_cmd.flush) begin
              state <= ST_FLUSH;
              idx   <= '0;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            idx       <= idx_inc;
            if (flush_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cnt <= q_cmd.count[AW-1:0];
    end
    if (q_pop && !q_cmd.flush) begin
      result.kind       <= q_cmd.kind;
      result.byte_out   <= q_cmd.byte_out;
      result.wake_level <= q_cmd.wake;
      result.last       <= 1'b1;
    end else if ((state == ST_FLUSH) && out_free) begin
      result.kind       <= KIND_TO_DOWN;
      result.byte_out   <= rd_data;
      result.wake_level <= 1'b1;
      result.last       <= flush_last;
    end
  end

  a_no_pop_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> !q_pop)
    else $error("queue popped during flush");

  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> !hold_wr.en)
    else $error("hold buffer written during flush");

  a_done_gives_last: assert property (@(posedge clk) disable iff (rst)
    bk_status.flush_done |=> (result.valid && result.last &&
                              (result.kind == KIND_TO_DOWN)))
    else $error("flush end without last byte");

endmodule

// ----- hw/rtl/wake_buffered_serial_bridge.sv -----
// ----------------------------------------------------------------------------
// wake_buffered_serial_bridge
// Two-port serial bridge with wake line control and a hold buffer.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request channel (valid/ready). mode 0 = timer tick, 1 = byte from
//            the upstream port, 2 = byte from the downstream port, 3 = ignored.
//   result : result channel (valid/ready). kind 0 = byte to downstream,
//            1 = byte to upstream, 2 = wake status change; last marks the
//            final result of a request.
//   APB    : start_delay at 0x0, idle_timeout at 0x4 (paddr[2] selects);
//            write only while idle. pready is tied high.
// Timing:
//   A request's single result passes through the command queue and then the
//   output register before it shows on result.
//   Requests stream at one per cycle while the two-entry command queue has
//   room and no flush is pending. A start-delay expiry queues a flush; the
//   back end then loads hold buffer bytes into the output register one per
//   cycle while it is free; item.ready stays low until the last one is loaded.
// Reset (rst, synchronous): phase stopped, timer halted, buffer empty, queue
//   and output register cleared, registers to 50 and 10000.
// Stall: result.ready low holds the output register; the back end stops, the
//   queue fills and item.ready drops. Nothing is dropped.
// ----------------------------------------------------------------------------
module wake_buffered_serial_bridge import wbsb_pkg::*; #(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wbsb_in_if.sink     item,
  wbsb_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [13:0] start_delay;
  logic [15:0] idle_timeout;
  logic        cfg_wr;

  logic        q_full, q_push, q_pop, q_avail;
  cmd_t        q_push_cmd, q_pop_cmd;
  hold_wr_t    hold_wr;
  bk_status_t  bk_status;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay  <= START_DELAY_RST;
      idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_DELAY) begin
        start_delay <= pwdata[13:0];
      end else begin
        idle_timeout <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_IDLE_TIMEOUT) begin
      prdata = {16'd0, idle_timeout};
    end else begin
      prdata = {18'd0, start_delay};
    end
  end

  // front: phase/timer control, hold buffer writes, command issue
  wbsb_front #(.HOLD_DEPTH(HOLD_DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .start_delay  (start_delay),
    .idle_timeout (idle_timeout),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_push_cmd),
    .hold_wr      (hold_wr),
    .bk_status    (bk_status)
  );

  // command queue decouples front from back
  wbsb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .avail    (q_avail)
  );

  // back: hold buffer, flush sequencer, output register
  wbsb_back #(.HOLD_DEPTH(HOLD_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .hold_wr   (hold_wr),
    .bk_status (bk_status),
    .result    (result)
  );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wake buffered serial bridge. A short table of
// directed requests is followed by random wake sessions, one deep-buffer
// session and a readback of the widest register values. Every accepted
// request goes through a cycle-free model of the bridge, and each result is
// checked field by field, in order, against that model or the directed row.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbsb_pkg::*;

  localparam int DEPTH = HOLD_DEPTH_DEF;

  // Mode 3 has no code in the package; the bridge drops it
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  // APB byte addresses, one word per register
  localparam logic [2:0] ADDR_START_DELAY  = {REG_START_DELAY, 2'b00};
  localparam logic [2:0] ADDR_IDLE_TIMEOUT = {REG_IDLE_TIMEOUT, 2'b00};

  // Cycles to let the pipe empty after the last expected result
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 60;

  typedef enum logic [1:0] {
    PH_STOPPED  = 2'd0,
    PH_STARTING = 2'd1,
    PH_STARTED  = 2'd2
  } bridge_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       wake;
    logic       last;
  } bridge_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e     op;
    logic [1:0]  mode;
    logic [7:0]  data;
    bit          typed;     // expected result written in the row itself
    bit          has_res;
    bridge_res_t res;
    logic        sel;       // register for ROW_CFG
    logic [15:0] value;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  wbsb_in_if  item_if ();
  wbsb_out_if result_if ();

  wake_buffered_serial_bridge #(
    .HOLD_DEPTH(DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bridge model state: phase, timer, hold buffer and the two registers
  // --------------------------------------------------------------------------
  bridge_phase_e ph;
  logic [15:0]   ticks_left;
  logic          tmr_on;
  logic [7:0]    held [DEPTH];
  int            held_n;
  logic [13:0]   start_dly;
  logic [15:0]   idle_to;

  bridge_res_t pending_results [$];   // results still owed by the bridge
  bridge_res_t got_exp;
  int          mismatch_count = 0;
  int          accepted_items = 0;
  bit          calm = 1'b0;           // both sides run without gaps

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, exp_v, act_v);
  endtask

  // Wake level reflects the phase after the request is applied
  function automatic bridge_res_t result_of(input logic [1:0] k, input logic [7:0] b);
    bridge_res_t r;
    r.kind     = k;
    r.byte_out = b;
    r.wake     = (ph != PH_STOPPED);
    r.last     = 1'b0;
    return r;
  endfunction

  // Apply one request to the model; queue its results when keep is set
  function automatic int bridge_step(input logic [1:0] m, input logic [7:0] d,
                                     input bit keep);
    bridge_res_t res [$];
    int i;
    if (m == MODE_TICK) begin
      if (tmr_on) begin
        if (ticks_left != 16'd0) ticks_left--;
        if (ticks_left == 16'd0) begin
          if (ph == PH_STARTING) begin
            // start delay over: flush the hold buffer in order
            ph = PH_STARTED;
            for (i = 0; i < held_n; i++) res.push_back(result_of(KIND_TO_DOWN, held[i]));
            held_n     = 0;
            ticks_left = idle_to;
          end else if (ph == PH_STARTED) begin
            ph     = PH_STOPPED;
            tmr_on = 1'b0;
            res.push_back(result_of(KIND_STATUS, 8'h00));
          end else begin
            tmr_on = 1'b0;
          end
        end
      end
    end else if (m == MODE_UP) begin
      if (ph == PH_STARTED) begin
        ticks_left = idle_to;
        tmr_on     = 1'b1;
        res.push_back(result_of(KIND_TO_DOWN, d));
      end else begin
        // nearly full: wrap and overwrite from the start
        if (held_n >= DEPTH - 1) held_n = 0;
        held[held_n] = d;
        held_n++;
        if (ph == PH_STOPPED) begin
          ph         = PH_STARTING;
          ticks_left = {2'b00, start_dly};
          tmr_on     = 1'b1;
          res.push_back(result_of(KIND_STATUS, 8'h00));
        end
      end
    end else if (m == MODE_DOWN) begin
      res.push_back(result_of(KIND_TO_UP, d));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    if (keep) foreach (res[i]) pending_results.push_back(res[i]);
    return res.size();
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; a request is taken at the
  // rising edge with valid and ready high, and the model is stepped there.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] m, input logic [7:0] d,
                           input bit typed = 1'b0, input bit typed_has = 1'b0,
                           input bridge_res_t typed_res = '0);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.mode  = m;
    item_if.data  = d;
    item_if.valid = 1'b1;
    do @(posedge clk); while (!item_if.ready);
    void'(bridge_step(m, d, !typed));
    if (typed && typed_has) pending_results.push_back(typed_res);
    if (m != MODE_IGNORED) accepted_items++;
    @(negedge clk);
  endtask

  // Hold requests until every owed result is out and the pipe is quiet
  task automatic settle();
    item_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // APB register access; both tasks start and end on a falling edge
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] a, input logic [31:0] v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = a;
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] a, output logic [31:0] v);
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = a;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    v = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write a register, mirror it in the model and read it back
  task automatic cfg_write(input logic sel, input logic [15:0] v);
    logic [31:0] rd;
    logic [31:0] want;
    if (sel == REG_START_DELAY) begin
      apb_write(ADDR_START_DELAY, {16'h0, v});
      start_dly = v[13:0];
      want      = {18'h0, v[13:0]};
      apb_read(ADDR_START_DELAY, rd);
    end else begin
      apb_write(ADDR_IDLE_TIMEOUT, {16'h0, v});
      idle_to = v;
      want    = {16'h0, v};
      apb_read(ADDR_IDLE_TIMEOUT, rd);
    end
    if (rd !== want) report_mismatch("register readback", want, rd);
  endtask

  // --------------------------------------------------------------------------
  // One wake session: first byte wakes the line, more bytes are held, the
  // start delay flushes them, traffic passes, and the idle timeout stops it.
  // --------------------------------------------------------------------------
  task automatic run_session(input int extra_held, input int started_ops, input bit quiet);
    int k;
    int pick;
    calm = quiet || ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(0, 2)) send_noise();
    send_item(MODE_UP, 8'($urandom));
    for (k = 0; k < extra_held; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(MODE_DOWN, 8'($urandom));
      if ($urandom_range(0, 15) == 0) send_item(MODE_IGNORED, 8'($urandom));
      send_item(MODE_UP, 8'($urandom));
    end
    while (ph == PH_STARTING) begin
      if ($urandom_range(0, 15) == 0) send_item(MODE_DOWN, 8'($urandom));
      send_item(MODE_TICK, 8'($urandom));
    end
    for (k = 0; k < started_ops; k++) begin
      pick = $urandom_range(0, 5);
      if (pick < 3) send_item(MODE_UP, 8'($urandom));
      else if (pick == 3) send_item(MODE_DOWN, 8'($urandom));
      else repeat ($urandom_range(1, 3)) send_item(MODE_TICK, 8'($urandom));
      // now and then let the result side run dry mid-session
      if ($urandom_range(0, 24) == 0) settle();
    end
    // a late byte may have started a new wake; run everything down to stopped
    while (ph != PH_STOPPED) send_item(MODE_TICK, 8'($urandom));
  endtask

  function automatic dir_row_t item_row(input logic [1:0] m, input logic [7:0] d);
    dir_row_t r;
    r       = '{op: ROW_ITEM, default: '0};
    r.op    = ROW_ITEM;
    r.mode  = m;
    r.data  = d;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [1:0] m, input logic [7:0] d,
                                         input bit has, input logic [1:0] k,
                                         input logic [7:0] b, input logic w);
    dir_row_t r;
    r         = item_row(m, d);
    r.typed   = 1'b1;
    r.has_res = has;
    r.res     = '{kind: k, byte_out: b, wake: w, last: 1'b1};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic sel, input logic [15:0] v);
    dir_row_t r;
    r       = '{op: ROW_CFG, default: '0};
    r.op    = ROW_CFG;
    r.sel   = sel;
    r.value = v;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: the sink draws a stall per result; checks at the taking edge
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    result_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready = 1'b1;
      do @(posedge clk); while (!result_if.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending, kind/byte",
                        {22'h0, result_if.kind, result_if.byte_out},
                        {22'h0, result_if.kind, result_if.byte_out});
      end else begin
        got_exp = pending_results.pop_front();
        if (result_if.kind !== got_exp.kind)
          report_mismatch("kind", 32'(got_exp.kind), 32'(result_if.kind));
        if (result_if.byte_out !== got_exp.byte_out)
          report_mismatch("byte_out", 32'(got_exp.byte_out), 32'(result_if.byte_out));
        if (result_if.wake_level !== got_exp.wake)
          report_mismatch("wake_level", 32'(got_exp.wake), 32'(result_if.wake_level));
        if (result_if.last !== got_exp.last)
          report_mismatch("last", 32'(got_exp.last), 32'(result_if.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t    dir_rows [25];
    logic [31:0] rd;
    int          i;
    int          base;
    int          sel;
    logic [15:0] sd;
    logic [15:0] it;

    item_if.valid = 1'b0;
    item_if.mode  = MODE_TICK;
    item_if.data  = 8'h00;

    ph         = PH_STOPPED;
    ticks_left = '0;
    tmr_on     = 1'b0;
    held_n     = 0;
    start_dly  = 14'd50;
    idle_to    = 16'd10000;

    // Defaults first (delay 50, timeout 10000), then zero timers, then a
    // short ordinary wake cycle with delay 2 and timeout 3.
    dir_rows[0]  = typed_row(MODE_DOWN, 8'h00, 1, KIND_TO_UP, 8'h00, 1'b0);
    dir_rows[1]  = typed_row(MODE_DOWN, 8'hFF, 1, KIND_TO_UP, 8'hFF, 1'b0);
    dir_rows[2]  = typed_row(MODE_IGNORED, 8'hA5, 0, KIND_TO_DOWN, 8'h00, 1'b0);
    dir_rows[3]  = typed_row(MODE_TICK, 8'hC3, 0, KIND_TO_DOWN, 8'h00, 1'b0); // timer idle
    dir_rows[4]  = cfg_row(REG_START_DELAY, 16'd0);
    dir_rows[5]  = typed_row(MODE_UP, 8'hFF, 1, KIND_STATUS, 8'h00, 1'b1);  // wake rises
    dir_rows[6]  = typed_row(MODE_UP, 8'h00, 0, KIND_TO_DOWN, 8'h00, 1'b0); // held
    dir_rows[7]  = typed_row(MODE_DOWN, 8'h5A, 1, KIND_TO_UP, 8'h5A, 1'b1);
    dir_rows[8]  = typed_row(MODE_IGNORED, 8'h3C, 0, KIND_TO_DOWN, 8'h00, 1'b0);
    dir_rows[9]  = item_row(MODE_TICK, 8'h00);                              // flush two
    dir_rows[10] = cfg_row(REG_IDLE_TIMEOUT, 16'd0);
    dir_rows[11] = typed_row(MODE_UP, 8'h81, 1, KIND_TO_DOWN, 8'h81, 1'b1);
    dir_rows[12] = typed_row(MODE_DOWN, 8'h7E, 1, KIND_TO_UP, 8'h7E, 1'b1);
    dir_rows[13] = typed_row(MODE_TICK, 8'hFF, 1, KIND_STATUS, 8'h00, 1'b0); // wake drops
    dir_rows[14] = typed_row(MODE_TICK, 8'h00, 0, KIND_TO_DOWN, 8'h00, 1'b0); // halted
    dir_rows[15] = cfg_row(REG_START_DELAY, 16'd2);
    dir_rows[16] = cfg_row(REG_IDLE_TIMEOUT, 16'd3);
    dir_rows[17] = typed_row(MODE_UP, 8'h55, 1, KIND_STATUS, 8'h00, 1'b1);
    dir_rows[18] = item_row(MODE_UP, 8'hAA);
    dir_rows[19] = item_row(MODE_TICK, 8'h00);
    dir_rows[20] = item_row(MODE_TICK, 8'h00);
    dir_rows[21] = item_row(MODE_UP, 8'h01);
    dir_rows[22] = item_row(MODE_TICK, 8'h00);
    dir_rows[23] = item_row(MODE_TICK, 8'h00);
    dir_rows[24] = item_row(MODE_TICK, 8'h00);

    // synchronous reset, held at the start and never asserted again
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset values of both registers
    apb_read(ADDR_START_DELAY, rd);
    if (rd !== 32'd50) report_mismatch("start_delay after reset", 32'd50, rd);
    apb_read(ADDR_IDLE_TIMEOUT, rd);
    if (rd !== 32'd10000) report_mismatch("idle_timeout after reset", 32'd10000, rd);

    // directed table
    for (i = 0; i < 25; i++) begin
      if (dir_rows[i].op == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[i].sel, dir_rows[i].value);
      end else begin
        send_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].typed,
                  dir_rows[i].has_res, dir_rows[i].res);
      end
    end

    // random sessions, small timer settings, reprogrammed every few sessions
    base = accepted_items;
    while (accepted_items - base < RANDOM_ITEMS) begin
      settle();
      sd = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
      it = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
      cfg_write(REG_START_DELAY, sd);
      cfg_write(REG_IDLE_TIMEOUT, it);
      repeat (3) begin
        sel = $urandom_range(0, 5);
        if (sel == 0) begin
          // broken traffic: any mode in any phase
          calm = 1'b0;
          repeat (8) send_noise();
        end else if (sel == 1) begin
          run_session($urandom_range(61, 64), $urandom_range(0, 6), 1'b0);
        end else begin
          run_session($urandom_range(0, 4), $urandom_range(0, 6), 1'b0);
        end
      end
    end

    // hold buffer wrapped once and refilled up to its wrap point before the flush
    settle();
    cfg_write(REG_START_DELAY, 16'd1);
    cfg_write(REG_IDLE_TIMEOUT, 16'd1);
    run_session(2 * DEPTH - 3, 1, 1'b0);

    // widest register values read back
    settle();
    cfg_write(REG_START_DELAY, 16'h3FFF);
    cfg_write(REG_IDLE_TIMEOUT, 16'hFFFF);

    calm = 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("PASS wake_buffered_serial_bridge");
    end else begin
      $display("FAIL wake_buffered_serial_bridge");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs
  initial begin
    #5_000_000;
    $display("FAIL wake_buffered_serial_bridge");
    $finish;
  end

endmodule
